### hdl/dvwt_pkg.sv
// Shared types, constants and the control store of the decaying visit/wait tracker.
package dvwt_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS    = 16;
    localparam int WAIT_BITS    = 16;
    localparam int AVG_BITS     = 32;
    localparam int TRIP_FIELD_W = 16;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int PROD_W       = 2 * Q_W;
    localparam int HALF_Q       = 1 << (FRAC_BITS - 1);

    localparam logic [Q_W-1:0]       ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int                   SIGMA_RESET_INT = (4 * (1 << FRAC_BITS) + 5) / 10;
    localparam logic [Q_W-1:0]       SIGMA_RESET = Q_W'(SIGMA_RESET_INT);
    localparam logic [WAIT_BITS-1:0] WAIT_MAX = {WAIT_BITS{1'b1}};
    localparam logic [WAIT_BITS-1:0] WAIT_ONE = {{(WAIT_BITS-1){1'b0}}, 1'b1};
    localparam logic [AVG_BITS-1:0]  AVG_MAX  = {AVG_BITS{1'b1}};

    // Control store addressing
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] UA_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] UA_SPLIT_W  = 4'd1;
    localparam logic [PC_W-1:0] UA_SPLIT_L  = 4'd2;
    localparam logic [PC_W-1:0] UA_GAP_CHK  = 4'd3;
    localparam logic [PC_W-1:0] UA_POW      = 4'd4;
    localparam logic [PC_W-1:0] UA_COEF_MUL = 4'd5;
    localparam logic [PC_W-1:0] UA_COEF_ADD = 4'd6;
    localparam logic [PC_W-1:0] UA_LEAVE    = 4'd7;
    localparam logic [PC_W-1:0] UA_AVG_ADD  = 4'd8;
    localparam logic [PC_W-1:0] UA_WAIT     = 4'd9;
    localparam logic [PC_W-1:0] UA_EMIT     = 4'd10;

    typedef enum logic [1:0] {
        KIND_WAIT  = 2'd0,
        KIND_LEAVE = 2'd1,
        KIND_ENTER = 2'd2,
        KIND_VISIT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_LOAD     = 4'd1,
        OP_WAIT_INC = 4'd2,
        OP_AVG_MUL  = 4'd3,
        OP_AVG_ADD  = 4'd4,
        OP_POW_STEP = 4'd5,
        OP_COEF_MUL = 4'd6,
        OP_COEF_ADD = 4'd7,
        OP_EMIT     = 4'd8
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_KIND     = 3'd2,
        COND_GAP_ZERO = 3'd3,
        COND_MORE_GAP = 3'd4
    } cond_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [TRIP_FIELD_W-1:0] trip_number;
    } req_item_t;

    typedef struct packed {
        logic [AVG_BITS-1:0]  average_wait;
        logic [Q_W-1:0]       visit_coefficient;
        logic [WAIT_BITS-1:0] current_wait;
    } rsp_item_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        kind_t           kind;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        dp_op_t op;
        logic   fire;
    } dp_ctl_t;

    typedef struct packed {
        kind_t kind;
        logic  gap_zero;
        logic  more_gap;
    } dp_status_t;

    // Microprogram: one control word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, kind: KIND_WAIT, target: UA_FETCH};
        case (addr)
            UA_FETCH:
            begin
                w.op   = OP_LOAD;
                w.cond = COND_NEXT;
            end
            UA_SPLIT_W:
            begin
                w.cond   = COND_KIND;
                w.kind   = KIND_WAIT;
                w.target = UA_WAIT;
            end
            UA_SPLIT_L:
            begin
                w.cond   = COND_KIND;
                w.kind   = KIND_LEAVE;
                w.target = UA_LEAVE;
            end
            UA_GAP_CHK:
            begin
                w.cond   = COND_GAP_ZERO;
                w.target = UA_COEF_MUL;
            end
            UA_POW:
            begin
                w.op     = OP_POW_STEP;
                w.cond   = COND_MORE_GAP;
                w.target = UA_POW;
            end
            UA_COEF_MUL:
            begin
                w.op     = OP_COEF_MUL;
                w.cond   = COND_KIND;
                w.kind   = KIND_VISIT;
                w.target = UA_EMIT;
            end
            UA_COEF_ADD:
            begin
                w.op     = OP_COEF_ADD;
                w.target = UA_EMIT;
            end
            UA_LEAVE:
            begin
                w.op   = OP_AVG_MUL;
                w.cond = COND_NEXT;
            end
            UA_AVG_ADD:
            begin
                w.op     = OP_AVG_ADD;
                w.target = UA_EMIT;
            end
            UA_WAIT:
            begin
                w.op   = OP_WAIT_INC;
                w.cond = COND_NEXT;
            end
            UA_EMIT:
            begin
                w.op     = OP_EMIT;
                w.target = UA_FETCH;
            end
            default:
            begin
                w.target = UA_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

### hdl/decaying_visit_wait_tracker.sv
// Decaying visit/wait tracker: top level joining the microcode sequencer and the datapath.
//
// Tracks wait and visit statistics for one grid site, one event per transaction, and
// returns one result per event with the state after it. The power loop of the
// microprogram steps through the bits of the forward trip gap, one square-and-multiply
// step per cycle, and the control store runs one step per cycle while it neither waits
// for a request nor waits at its final step for the previous result to be taken.
// A finished result sits in an output register, so the next event is accepted while
// the previous result waits; a result held longer than the next event's work stalls
// the sequencer at its final step. Sigma is written through cfg_write/cfg_wdata; the
// user must write it only while the block is idle, as the block does not enforce this.
// Values above 1.0 act as 1.0.
module decaying_visit_wait_tracker #(
    parameter int TRIP_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [dvwt_pkg::Q_W-1:0]  cfg_wdata,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  dvwt_pkg::req_item_t       req_item,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output dvwt_pkg::rsp_item_t       rsp_item
);
    import dvwt_pkg::*;

    dp_ctl_t    ctl;
    dp_status_t status;

    // Control: step counter and control store
    dvwt_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .ctl       (ctl)
    );

    // Arithmetic and state
    dvwt_datapath #(
        .TRIP_BITS (TRIP_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_wdata (cfg_wdata),
        .req_item  (req_item),
        .ctl       (ctl),
        .status    (status),
        .rsp_item  (rsp_item)
    );

endmodule

### hdl/dvwt_useq.sv
// Microcode sequencer: step counter, control store, branch logic and result handshake.
module dvwt_useq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  dvwt_pkg::dp_status_t  status,
    output dvwt_pkg::dp_ctl_t     ctl
);
    import dvwt_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    ucode_t          uw;
    logic            fire;
    logic            taken;

    // Fetch the current control word
    assign uw = ucode_rom(pc_reg);

    // Decide whether this step executes and where it goes next
    always_comb
    begin
        case (uw.op)
            OP_LOAD: fire = req_valid;
            OP_EMIT: fire = !rsp_valid_reg || rsp_ready;
            default: fire = 1'b1;
        endcase

        case (uw.cond)
            COND_NEXT:     taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_KIND:     taken = (status.kind == uw.kind);
            COND_GAP_ZERO: taken = status.gap_zero;
            COND_MORE_GAP: taken = status.more_gap;
            default:       taken = 1'b0;
        endcase

        if (!fire)
            pc_next = pc_reg;
        else if (taken)
            pc_next = uw.target;
        else
            pc_next = pc_reg + 1'b1;

        // Set on a new result, drop once the transaction completes
        if (uw.op == OP_EMIT && fire)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= UA_FETCH;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (uw.op == OP_LOAD);
    assign rsp_valid = rsp_valid_reg;
    assign ctl.op    = uw.op;
    assign ctl.fire  = fire;

endmodule

### hdl/dvwt_datapath.sv
// Datapath: site state, sigma register, fixed-point multipliers, one of them shared, and result register.
module dvwt_datapath #(
    parameter int TRIP_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [dvwt_pkg::Q_W-1:0]      cfg_wdata,
    input  dvwt_pkg::req_item_t           req_item,
    input  dvwt_pkg::dp_ctl_t             ctl,
    output dvwt_pkg::dp_status_t          status,
    output dvwt_pkg::rsp_item_t           rsp_item
);
    import dvwt_pkg::*;

    localparam int AVG_PW = AVG_BITS + Q_W;
    localparam int WS_W   = WAIT_BITS + Q_W;

    // Architectural state
    logic [Q_W-1:0]       sigma_reg,     sigma_next;
    logic [AVG_BITS-1:0]  avg_reg,       avg_next;
    logic [WAIT_BITS-1:0] wait_reg,      wait_next;
    logic [Q_W-1:0]       coef_reg,      coef_next;
    logic [TRIP_BITS-1:0] last_trip_reg, last_trip_next;

    // Working registers of one transaction
    logic [AVG_BITS-1:0]  tmp_reg,  tmp_next;
    logic [Q_W-1:0]       base_reg, base_next;
    logic [Q_W-1:0]       pw_reg,   pw_next;
    logic [TRIP_BITS-1:0] gap_reg,  gap_next;
    logic [TRIP_BITS-1:0] trip_reg, trip_next;
    kind_t                kind_reg, kind_next;
    rsp_item_t            rsp_reg,  rsp_next;

    logic [Q_W-1:0]              sig_q;
    logic [Q_W-1:0]              om_q;
    logic [TRIP_BITS+TRIP_FIELD_W-1:0] trip_ext;
    logic [TRIP_BITS-1:0]        trip_in;
    logic [TRIP_BITS-1:0]        gap_in;
    logic [Q_W-1:0]              mul_a, mul_b;
    logic [PROD_W-1:0]           prod_ab, prod_bb;
    logic [PROD_W:0]             rnd_ab, rnd_bb;
    logic [Q_W-1:0]              q_ab, q_bb;
    logic [AVG_PW-1:0]           prod_avg;
    logic [AVG_PW:0]             rnd_avg;
    logic [WS_W-1:0]             prod_ws;
    logic [AVG_BITS+1:0]         avg_sum;
    logic [Q_W:0]                coef_sum;

    // Clamp sigma to 1.0 and form 1 - sigma
    assign sig_q = (sigma_reg > ONE_Q) ? ONE_Q : sigma_reg;
    assign om_q  = ONE_Q - sig_q;

    // Trip gap, a backward step counts as zero
    assign trip_ext = {{TRIP_BITS{1'b0}}, req_item.trip_number};
    assign trip_in  = trip_ext[TRIP_BITS-1:0];
    assign gap_in   = (trip_in > last_trip_reg) ? (trip_in - last_trip_reg) : '0;

    // Shared Q-format multiplier: running power or coefficient update
    assign mul_a   = (ctl.op == OP_COEF_MUL) ? coef_reg : pw_reg;
    assign mul_b   = (ctl.op == OP_COEF_MUL) ? pw_reg : base_reg;
    assign prod_ab = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rnd_ab  = {1'b0, prod_ab} + (PROD_W+1)'(HALF_Q);
    assign q_ab    = rnd_ab[FRAC_BITS +: Q_W];

    // Squaring multiplier for the base
    assign prod_bb = PROD_W'(base_reg) * PROD_W'(base_reg);
    assign rnd_bb  = {1'b0, prod_bb} + (PROD_W+1)'(HALF_Q);
    assign q_bb    = rnd_bb[FRAC_BITS +: Q_W];

    // Average decay and the exact sigma-times-wait term
    assign prod_avg = AVG_PW'(avg_reg) * AVG_PW'(om_q);
    assign rnd_avg  = {1'b0, prod_avg} + (AVG_PW+1)'(HALF_Q);
    assign prod_ws  = WS_W'(wait_reg) * WS_W'(sig_q);
    assign avg_sum  = (AVG_BITS+2)'(tmp_reg) + (AVG_BITS+2)'(prod_ws);

    assign coef_sum = {1'b0, coef_reg} + {1'b0, sig_q};

    // Execute the control word
    always_comb
    begin
        sigma_next     = cfg_write ? cfg_wdata : sigma_reg;
        avg_next       = avg_reg;
        wait_next      = wait_reg;
        coef_next      = coef_reg;
        last_trip_next = last_trip_reg;
        tmp_next       = tmp_reg;
        base_next      = base_reg;
        pw_next        = pw_reg;
        gap_next       = gap_reg;
        trip_next      = trip_reg;
        kind_next      = kind_reg;
        rsp_next       = rsp_reg;

        if (ctl.fire)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    kind_next = kind_t'(req_item.kind);
                    trip_next = trip_in;
                    gap_next  = gap_in;
                    base_next = om_q;
                    pw_next   = ONE_Q;
                end
                OP_WAIT_INC:
                begin
                    if (wait_reg != WAIT_MAX)
                        wait_next = wait_reg + 1'b1;
                end
                OP_AVG_MUL:
                begin
                    tmp_next = rnd_avg[FRAC_BITS +: AVG_BITS];
                end
                OP_AVG_ADD:
                begin
                    avg_next  = (|avg_sum[AVG_BITS+1:AVG_BITS]) ? AVG_MAX
                                                                : avg_sum[AVG_BITS-1:0];
                    wait_next = WAIT_ONE;
                end
                OP_POW_STEP:
                begin
                    if (gap_reg[0])
                        pw_next = q_ab;
                    base_next = q_bb;
                    gap_next  = {1'b0, gap_reg[TRIP_BITS-1:1]};
                end
                OP_COEF_MUL:
                begin
                    coef_next      = q_ab;
                    last_trip_next = trip_reg;
                end
                OP_COEF_ADD:
                begin
                    coef_next = (coef_sum > {1'b0, ONE_Q}) ? ONE_Q : coef_sum[Q_W-1:0];
                    wait_next = WAIT_ONE;
                end
                OP_EMIT:
                begin
                    rsp_next.average_wait      = avg_reg;
                    rsp_next.visit_coefficient = coef_reg;
                    rsp_next.current_wait      = wait_reg;
                end
                default:
                begin
                    tmp_next = tmp_reg;
                end
            endcase
        end
    end

    // Site state and sigma: reset by rst_n, held across transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= SIGMA_RESET;
            avg_reg       <= '0;
            wait_reg      <= WAIT_ONE;
            coef_reg      <= ONE_Q;
            last_trip_reg <= '0;
        end
        else
        begin
            sigma_reg     <= sigma_next;
            avg_reg       <= avg_next;
            wait_reg      <= wait_next;
            coef_reg      <= coef_next;
            last_trip_reg <= last_trip_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        tmp_reg  <= tmp_next;
        base_reg <= base_next;
        pw_reg   <= pw_next;
        gap_reg  <= gap_next;
        trip_reg <= trip_next;
        kind_reg <= kind_next;
        rsp_reg  <= rsp_next;
    end

    assign status.kind     = kind_reg;
    assign status.gap_zero = (gap_reg == '0);
    assign status.more_gap = |gap_reg[TRIP_BITS-1:1];
    assign rsp_item        = rsp_reg;

endmodule

### tb/decaying_visit_wait_tracker_tb.sv
// Self-checking testbench for the decaying visit/wait tracker.
`timescale 1ns / 1ps

module decaying_visit_wait_tracker_tb;

    import dvwt_pkg::*;

    localparam int          TIMEOUT_CYCLES = 3_000_000;
    localparam int          SETTLE_CYCLES  = 30;
    localparam int          RANDOM_PER_RUN = 232;
    localparam logic [63:0] FX_ONE         = 64'(1) << FRAC_BITS;
    localparam logic [63:0] FX_HALF        = 64'(1) << (FRAC_BITS - 1);

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_write = 1'b0;
    logic [Q_W-1:0]  cfg_wdata = '0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    req_item_t       req_item  = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    rsp_item_t       rsp_item;

    // Site state as the tracker should hold it
    logic [Q_W-1:0]       site_sigma;
    logic [63:0]          site_avg;
    logic [63:0]          site_wait;
    logic [63:0]          site_coef;
    logic [15:0]          site_last_trip;

    req_item_t            pending_events[$];
    rsp_item_t            expected_stats[$];
    logic [15:0]          stim_trip;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   error_count;
    int                   cycle_count;
    logic                 holding;

    decaying_visit_wait_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rounded fixed-point product
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + FX_HALF) >> FRAC_BITS;
    endfunction

    // Raise the keep factor to the trip gap by square and multiply
    function automatic logic [63:0] decay_factor(input logic [63:0] base,
                                                 input logic [15:0] gap);
        logic [63:0] acc;
        acc = FX_ONE;
        for (int i = 0; i < 16; i++)
        begin
            if (gap[i])
                acc = fx_mul(acc, base);
            base = fx_mul(base, base);
        end
        return acc;
    endfunction

    // Apply one event to the site state and return the stats after it
    function automatic rsp_item_t track_event(input req_item_t ev);
        logic [63:0] sig;
        logic [63:0] keep;
        logic [63:0] sum;
        logic [15:0] gap;
        rsp_item_t   stats;
        sig  = (64'(site_sigma) > FX_ONE) ? FX_ONE : 64'(site_sigma);
        keep = FX_ONE - sig;
        gap  = (ev.trip_number > site_last_trip) ? ev.trip_number - site_last_trip : 16'd0;
        case (kind_t'(ev.kind))
            KIND_WAIT:
            begin
                if (site_wait < 64'(WAIT_MAX))
                    site_wait = site_wait + 1;
            end
            KIND_LEAVE:
            begin
                sum       = fx_mul(site_avg, keep) + site_wait * sig;
                site_avg  = (sum > 64'(AVG_MAX)) ? 64'(AVG_MAX) : sum;
                site_wait = 1;
            end
            KIND_ENTER:
            begin
                site_wait      = 1;
                site_coef      = fx_mul(site_coef, decay_factor(keep, gap));
                site_last_trip = ev.trip_number;
                site_coef      = site_coef + sig;
                if (site_coef > FX_ONE)
                    site_coef = FX_ONE;
            end
            default:
            begin
                site_coef      = fx_mul(site_coef, decay_factor(keep, gap));
                site_last_trip = ev.trip_number;
            end
        endcase
        stats.average_wait      = site_avg[AVG_BITS-1:0];
        stats.visit_coefficient = site_coef[Q_W-1:0];
        stats.current_wait      = site_wait[WAIT_BITS-1:0];
        return stats;
    endfunction

    function automatic void queue_event(input kind_t k, input logic [15:0] trip);
        req_item_t ev;
        ev.kind        = k;
        ev.trip_number = trip;
        pending_events.push_back(ev);
    endfunction

    // Mostly forward trip steps, with jumps, repeats and backward trips mixed in
    function automatic void queue_random_events(input int count);
        int    pick;
        int    trip_pick;
        kind_t k;
        logic [15:0] trip;
        for (int n = 0; n < count; n++)
        begin
            pick      = $urandom_range(99);
            trip_pick = $urandom_range(99);
            k = (pick < 40) ? KIND_WAIT : (pick < 55) ? KIND_LEAVE :
                (pick < 75) ? KIND_ENTER : KIND_VISIT;
            if (trip_pick < 70)
                trip = stim_trip + 16'($urandom_range(12));
            else if (trip_pick < 85)
                trip = 16'($urandom);
            else if (trip_pick < 95)
                trip = stim_trip - 16'($urandom_range(50, 1));
            else
                trip = stim_trip;
            if (k == KIND_ENTER || k == KIND_VISIT)
                stim_trip = trip;
            queue_event(k, trip);
        end
    endfunction

    // Hold until every event is answered, then let the sequencer settle
    task automatic wait_for_drain();
        while (pending_events.size() != 0 || expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sigma(input logic [Q_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_write  <= 1'b0;
        site_sigma  = value;
    endtask

    // Drive request transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item  <= '0;
        end
        else
        begin
            holding = req_valid;
            if (req_valid && req_ready)
            begin
                expected_stats.push_back(track_event(req_item));
                void'(pending_events.pop_front());
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_item  <= pending_events[0];
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Check response transactions against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("unexpected response transaction: %p", rsp_item);
                    error_count++;
                end
                else
                begin
                    if (rsp_item.average_wait !== expected_stats[0].average_wait)
                    begin
                        $error("average_wait: expected %0h, got %0h",
                               expected_stats[0].average_wait, rsp_item.average_wait);
                        error_count++;
                    end
                    if (rsp_item.visit_coefficient !== expected_stats[0].visit_coefficient)
                    begin
                        $error("visit_coefficient: expected %0h, got %0h",
                               expected_stats[0].visit_coefficient,
                               rsp_item.visit_coefficient);
                        error_count++;
                    end
                    if (rsp_item.current_wait !== expected_stats[0].current_wait)
                    begin
                        $error("current_wait: expected %0h, got %0h",
                               expected_stats[0].current_wait, rsp_item.current_wait);
                        error_count++;
                    end
                    void'(expected_stats.pop_front());
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("decaying_visit_wait_tracker verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [Q_W-1:0] sigma_list[8];
        sigma_list = '{17'd26214, 17'd0, 17'd65536, 17'd1, 17'd131071, 17'd65537,
                       17'd32768, 17'($urandom_range(131071))};
        site_sigma     = SIGMA_RESET;
        site_avg       = 0;
        site_wait      = 1;
        site_coef      = FX_ONE;
        site_last_trip = 0;
        stim_trip      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and corner cases under the reset sigma
        queue_event(KIND_VISIT, 16'h0000);
        queue_event(KIND_WAIT,  16'hFFFF);
        queue_event(KIND_WAIT,  16'h0000);
        queue_event(KIND_WAIT,  16'hAAAA);
        queue_event(KIND_LEAVE, 16'h5555);
        queue_event(KIND_LEAVE, 16'h0000);
        queue_event(KIND_ENTER, 16'h0001);
        queue_event(KIND_ENTER, 16'h0001);  // coefficient overflows past 1.0
        queue_event(KIND_VISIT, 16'hFFFF);  // full-width trip gap
        queue_event(KIND_VISIT, 16'h0064);  // backward trip
        queue_event(KIND_VISIT, 16'h0064);
        queue_event(KIND_VISIT, 16'h8000);
        queue_event(KIND_ENTER, 16'h7FFF);  // backward trip on enter
        queue_event(KIND_WAIT,  16'h0000);
        queue_event(KIND_WAIT,  16'h0000);
        queue_event(KIND_ENTER, 16'hFFFF);
        queue_event(KIND_LEAVE, 16'hFFFF);
        queue_event(KIND_VISIT, 16'hFFFF);
        queue_event(KIND_VISIT, 16'hAAAA);
        queue_event(KIND_ENTER, 16'h5555);
        queue_event(KIND_WAIT,  16'h1234);
        queue_event(KIND_LEAVE, 16'h0000);
        wait_for_drain();

        // Random runs over sigma settings and idle patterns
        for (int run = 0; run < 8; run++)
        begin
            if (run != 0)
                write_sigma(sigma_list[run]);
            case (run % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            queue_random_events(RANDOM_PER_RUN / 2);
            wait_for_drain();
            queue_random_events(RANDOM_PER_RUN / 2);
            wait_for_drain();
        end

        if (error_count == 0)
            $display("decaying_visit_wait_tracker verification clean");
        else
            $display("decaying_visit_wait_tracker verification failed");
        $finish;
    end

endmodule

### decaying_visit_wait_tracker.f
hdl/dvwt_pkg.sv
hdl/dvwt_useq.sv
hdl/dvwt_datapath.sv
hdl/decaying_visit_wait_tracker.sv
tb/decaying_visit_wait_tracker_tb.sv
